### src/ogf_pkg.sv
// ----------------------------------------------------------------------------
// ogf_pkg
// Shared widths, constants and types of the obstacle gradient force filter.
// ----------------------------------------------------------------------------
package ogf_pkg;

    localparam int COST_W  = 8;   // one cost cell, signed
    localparam int DIFF_W  = 7;   // saturated half difference, signed
    localparam int GAIN_W  = 16;  // Q8.8 gain, signed
    localparam int FORCE_W = 14;  // output force, signed Q6.8
    localparam int MAG_W   = 22;  // force magnitude before clamp, also root width
    localparam int PROD_W  = 44;  // multiplier product and squared magnitude
    localparam int NUM_W   = 36;  // rounded dividend
    localparam int REM_W   = 26;  // partial remainder of the iterative unit
    localparam int STEP_W  = 5;   // iteration counter

    localparam logic [STEP_W-1:0] DIV_MEAN_STEPS = STEP_W'(22);
    localparam logic [STEP_W-1:0] DIV_CLAMP_STEPS = STEP_W'(14);
    localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(22);

    localparam logic [FORCE_W-2:0] FORCE_CAP = 13'd7680;      // 30 N in Q8.8
    localparam logic [PROD_W-1:0]  FORCE_CAP_SQ = 44'd58982400;

    // register indexes of the write port
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_OBSTACLE_GAIN = 1'b1;

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } t_iter_mode;

    typedef struct packed {
        logic              start;
        t_iter_mode        mode;
        logic [STEP_W-1:0] steps;
    } t_iter_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] result;
    } t_iter_rsp;

endpackage

### src/ogf_in_if.sv
// ----------------------------------------------------------------------------
// ogf_in_if
// Input channel: one beat carries the four cost cells around the map center.
// ----------------------------------------------------------------------------
interface ogf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ogf_pkg::COST_W-1:0]   cost_right;
    logic signed [ogf_pkg::COST_W-1:0]   cost_left;
    logic signed [ogf_pkg::COST_W-1:0]   cost_below;
    logic signed [ogf_pkg::COST_W-1:0]   cost_above;

    modport source (
        output valid, cost_right, cost_left, cost_below, cost_above,
        input  ready
    );
    modport sink (
        input  valid, cost_right, cost_left, cost_below, cost_above,
        output ready
    );
endinterface

### src/ogf_out_if.sv
// ----------------------------------------------------------------------------
// ogf_out_if
// Output channel: one beat carries the filtered force and the clamp flag.
// ----------------------------------------------------------------------------
interface ogf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ogf_pkg::FORCE_W-1:0]   force_x;
    logic signed [ogf_pkg::FORCE_W-1:0]   force_y;
    logic                                 was_clamped;

    modport source (
        output valid, force_x, force_y, was_clamped,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, was_clamped,
        output ready
    );
endinterface

### src/ogf_ram.sv
// ----------------------------------------------------------------------------
// ogf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogf_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/ogf_iter.sv
// ----------------------------------------------------------------------------
// ogf_iter
// Shared iterative unit: restoring divide (one quotient bit per cycle) or
// integer square root (one root bit per cycle) on one compare-subtract.
// ----------------------------------------------------------------------------
module ogf_iter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ogf_pkg::t_iter_req                i_req,
    input  logic [ogf_pkg::REM_W-1:0]         i_rem_init,
    input  logic [ogf_pkg::PROD_W-1:0]        i_bits,
    input  logic [ogf_pkg::MAG_W-1:0]         i_den,
    output ogf_pkg::t_iter_rsp                o_rsp
);
    localparam int RemW  = ogf_pkg::REM_W;
    localparam int BitsW = ogf_pkg::PROD_W;
    localparam int MagW  = ogf_pkg::MAG_W;

    logic                          r_busy;
    logic                          r_done;
    logic [ogf_pkg::STEP_W-1:0]    r_cnt;
    ogf_pkg::t_iter_mode           r_mode;
    logic [RemW-1:0]               r_rem;
    logic [BitsW-1:0]              r_bits;
    logic [MagW-1:0]               r_den;
    logic [MagW-1:0]               r_q;

    logic [RemW-1:0]               cand;
    logic [RemW-1:0]               sub_b;
    logic [RemW:0]                 diff;
    logic                          ge;

    // sqrt brings down two bits against trial {root, 01}; divide one bit
    always_comb begin
        if (r_mode == ogf_pkg::ITER_SQRT) begin
            cand  = {r_rem[RemW-3:0], r_bits[BitsW-1 -: 2]};
            sub_b = {{(RemW-MagW-2){1'b0}}, r_q, 2'b01};
        end else begin
            cand  = {r_rem[RemW-2:0], r_bits[BitsW-1]};
            sub_b = {{(RemW-MagW){1'b0}}, r_den};
        end
        diff = {1'b0, cand} - {1'b0, sub_b};
        ge   = ~diff[RemW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ogf_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_rem  <= i_rem_init;
            r_bits <= i_bits;
            r_den  <= i_den;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[RemW-1:0] : cand;
            r_q   <= {r_q[MagW-2:0], ge};
            if (r_mode == ogf_pkg::ITER_SQRT) begin
                r_bits <= {r_bits[BitsW-3:0], 2'b00};
            end else begin
                r_bits <= {r_bits[BitsW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;
endmodule

### src/obstacle_gradient_force_filter_core.sv
// ----------------------------------------------------------------------------
// obstacle_gradient_force_filter_core
// Each input beat runs two mean divides on the shared divide/sqrt unit;
// when the clamp applies, a root and two clamp divides follow. A new input
// beat is taken only in S_IDLE, after the previous result has gone to the
// output register, so a stalled output holds the core. Synchronous active-low reset
// sets window_length to 1, obstacle_gain to 1.0 and empties both windows.
// Window RAM contents are never cleared; only slots written since the last
// clear are read back.
// ----------------------------------------------------------------------------
module obstacle_gradient_force_filter_core #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ogf_in_if.sink                          i_in,
    ogf_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [ogf_pkg::GAIN_W-1:0]      i_cfg_wdata
);
    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int SW    = ogf_pkg::DIFF_W + $clog2(WINDOW_MAX);
    localparam int DW    = ogf_pkg::DIFF_W;
    localparam int MagW  = ogf_pkg::MAG_W;
    localparam int ProdW = ogf_pkg::PROD_W;
    localparam int NumW  = ogf_pkg::NUM_W;
    localparam int RemW  = ogf_pkg::REM_W;
    localparam int FW    = ogf_pkg::FORCE_W;
    localparam int GW    = ogf_pkg::GAIN_W;
    localparam int MeanQ = 22;   // quotient bits of the mean divide
    localparam int ClampQ = 14;  // quotient bits of the clamp divide

    typedef enum logic [4:0] {
        S_IDLE,   // waiting for an input beat
        S_UPD,    // window and running sums update
        S_MULX,   // |sum_x| * |gain|
        S_DVX,    // launch mean divide x
        S_WDX,
        S_MULY,
        S_DVY,
        S_WDY,
        S_SQX,    // fx^2
        S_SQY,    // fy^2
        S_SUM,    // fx^2 + fy^2
        S_CMP,    // clamp check, launch root
        S_WSQ,
        S_MCX,    // |fx| * cap
        S_DCX,
        S_WCX,
        S_MCY,
        S_DCY,
        S_WCY,
        S_OUT     // hand result to the output register
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_len;
    logic signed [GW-1:0]       r_gain;
    logic [AW-1:0]              r_slot;
    logic [CW-1:0]              r_count;
    logic signed [SW-1:0]       r_sum_x;
    logic signed [SW-1:0]       r_sum_y;
    logic signed [DW-1:0]       r_dx;
    logic signed [DW-1:0]       r_dy;
    logic [ProdW-1:0]           r_prod;
    logic [ProdW-1:0]           r_m2;
    logic [MagW-1:0]            r_fx_mag;
    logic [MagW-1:0]            r_fy_mag;
    logic                       r_fx_neg;
    logic                       r_fy_neg;
    logic [MagW-1:0]            r_mag;
    logic                       r_clamp;
    logic                       r_out_valid;
    logic signed [FW-1:0]       r_out_fx;
    logic signed [FW-1:0]       r_out_fy;
    logic                       r_out_clamp;

    // iterative unit request, registered
    ogf_pkg::t_iter_req         r_req;
    logic [RemW-1:0]            r_rem_init;
    logic [ProdW-1:0]           r_bits;
    logic [MagW-1:0]            r_den;
    ogf_pkg::t_iter_rsp         iter_rsp;

    logic [2*DW-1:0]            ram_rdata;
    logic                       ram_we;
    logic signed [DW-1:0]       old_x;
    logic signed [DW-1:0]       old_y;

    logic                       win_full;
    logic signed [SW:0]         n_sum_x;
    logic signed [SW:0]         n_sum_y;
    logic [SW-1:0]              sum_x_abs;
    logic [SW-1:0]              sum_y_abs;
    logic [GW-1:0]              gain_abs;
    logic [MagW-1:0]            mul_a;
    logic [MagW-1:0]            mul_b;
    logic [ProdW-1:0]           mul_p;
    logic [NumW-1:0]            div_add;
    logic [NumW-1:0]            div_num;
    logic [MagW-1:0]            clamp_q;
    logic [4:0]                 cfg_len5;
    logic [CW-1:0]              cfg_len;
    logic                       in_beat;

    // -(after - before) / 2, truncated toward zero, saturated to 7 bits
    function automatic logic signed [DW-1:0] half_diff(
        input logic signed [ogf_pkg::COST_W-1:0] after_c,
        input logic signed [ogf_pkg::COST_W-1:0] before_c
    );
        logic signed [ogf_pkg::COST_W:0] d;
        logic signed [ogf_pkg::COST_W:0] h;
        logic signed [ogf_pkg::COST_W:0] n;
        d = {after_c[ogf_pkg::COST_W-1], after_c} - {before_c[ogf_pkg::COST_W-1], before_c};
        h = d[ogf_pkg::COST_W] ? ((d + 9'sd1) >>> 1) : (d >>> 1);
        n = -h;
        if (n > 9'sd63) begin
            half_diff = 7'sd63;
        end else if (n < -9'sd64) begin
            half_diff = -7'sd64;
        end else begin
            half_diff = n[DW-1:0];
        end
    endfunction

    ogf_ram #(
        .WIDTH (2 * DW),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata ({r_dx, r_dy}),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    ogf_iter u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_req),
        .i_rem_init (r_rem_init),
        .i_bits     (r_bits),
        .i_den      (r_den),
        .o_rsp      (iter_rsp)
    );

    assign in_beat = i_in.valid && i_in.ready;
    assign ram_we  = (r_state == S_UPD);
    assign old_x   = ram_rdata[2*DW-1:DW];
    assign old_y   = ram_rdata[DW-1:0];

    // window update: drop the oldest sample once the window is full
    always_comb begin
        win_full = (r_count == r_len);
        n_sum_x  = {r_sum_x[SW-1], r_sum_x} + (SW+1)'(r_dx);
        n_sum_y  = {r_sum_y[SW-1], r_sum_y} + (SW+1)'(r_dy);
        if (win_full) begin
            n_sum_x = n_sum_x - (SW+1)'(old_x);
            n_sum_y = n_sum_y - (SW+1)'(old_y);
        end
    end

    assign sum_x_abs = r_sum_x[SW-1] ? SW'(-r_sum_x) : SW'(r_sum_x);
    assign sum_y_abs = r_sum_y[SW-1] ? SW'(-r_sum_y) : SW'(r_sum_y);
    assign gain_abs  = r_gain[GW-1] ? GW'(-r_gain) : GW'(r_gain);

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MULX: begin
                mul_a = MagW'(sum_x_abs);
                mul_b = MagW'(gain_abs);
            end
            S_MULY: begin
                mul_a = MagW'(sum_y_abs);
                mul_b = MagW'(gain_abs);
            end
            S_SQX: begin
                mul_a = r_fx_mag;
                mul_b = r_fx_mag;
            end
            S_SQY: begin
                mul_a = r_fy_mag;
                mul_b = r_fy_mag;
            end
            S_MCX: begin
                mul_a = r_fx_mag;
                mul_b = MagW'(ogf_pkg::FORCE_CAP);
            end
            S_MCY: begin
                mul_a = r_fy_mag;
                mul_b = MagW'(ogf_pkg::FORCE_CAP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round half away from zero: add half the divisor to the magnitude
    assign div_add = ((r_state == S_DCX) || (r_state == S_DCY))
                   ? NumW'(r_mag >> 1) : NumW'(r_count >> 1);
    assign div_num = r_prod[NumW-1:0] + div_add;

    assign clamp_q = (iter_rsp.result > MagW'(ogf_pkg::FORCE_CAP))
                   ? MagW'(ogf_pkg::FORCE_CAP) : iter_rsp.result;

    // window_length: zero reads as 1, above the store depth saturates
    always_comb begin
        cfg_len5 = i_cfg_wdata[4:0];
        if (cfg_len5 == 5'd0) begin
            cfg_len = CW'(1);
        end else if (int'(cfg_len5) > WINDOW_MAX) begin
            cfg_len = CW'(WINDOW_MAX);
        end else begin
            cfg_len = CW'(cfg_len5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= CW'(1);
            r_gain      <= 16'sd256;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_out_valid <= 1'b0;
            r_req       <= '0;
            r_clamp     <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    ogf_pkg::REG_WINDOW_LENGTH: begin
                        r_len   <= cfg_len;
                        r_slot  <= '0;
                        r_count <= '0;
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                    end
                    ogf_pkg::REG_OBSTACLE_GAIN: begin
                        r_gain <= i_cfg_wdata;
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_dx    <= half_diff(i_in.cost_right, i_in.cost_left);
                        r_dy    <= half_diff(i_in.cost_below, i_in.cost_above);
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_sum_x <= n_sum_x[SW-1:0];
                    r_sum_y <= n_sum_y[SW-1:0];
                    if (!win_full) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (CW'(r_slot) == r_len - 1'b1) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                    r_state <= S_MULX;
                end
                S_MULX: begin
                    r_prod  <= mul_p;
                    r_state <= S_DVX;
                end
                S_DVX, S_DVY: begin
                    r_req.start <= 1'b1;
                    r_req.mode  <= ogf_pkg::ITER_DIV;
                    r_req.steps <= ogf_pkg::DIV_MEAN_STEPS;
                    r_rem_init  <= RemW'(div_num[NumW-1:MeanQ]);
                    r_bits      <= {div_num[MeanQ-1:0], {(ProdW-MeanQ){1'b0}}};
                    r_den       <= MagW'(r_count);
                    r_state     <= (r_state == S_DVX) ? S_WDX : S_WDY;
                end
                S_WDX: begin
                    if (iter_rsp.done) begin
                        r_fx_mag <= iter_rsp.result;
                        r_fx_neg <= r_sum_x[SW-1] ^ r_gain[GW-1];
                        r_state  <= S_MULY;
                    end
                end
                S_MULY: begin
                    r_prod  <= mul_p;
                    r_state <= S_DVY;
                end
                S_WDY: begin
                    if (iter_rsp.done) begin
                        r_fy_mag <= iter_rsp.result;
                        r_fy_neg <= r_sum_y[SW-1] ^ r_gain[GW-1];
                        r_state  <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_prod  <= mul_p;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_m2    <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_m2    <= r_m2 + r_prod;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_m2 > ogf_pkg::FORCE_CAP_SQ) begin
                        r_clamp     <= 1'b1;
                        r_req.start <= 1'b1;
                        r_req.mode  <= ogf_pkg::ITER_SQRT;
                        r_req.steps <= ogf_pkg::SQRT_STEPS;
                        r_rem_init  <= '0;
                        r_bits      <= r_m2;
                        r_den       <= '0;
                        r_state     <= S_WSQ;
                    end else begin
                        r_clamp <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_WSQ: begin
                    if (iter_rsp.done) begin
                        r_mag   <= iter_rsp.result;
                        r_state <= S_MCX;
                    end
                end
                S_MCX: begin
                    r_prod  <= mul_p;
                    r_state <= S_DCX;
                end
                // quotient stays below 2^14 since |f| <= mag, so the top
                // dividend bits preload the remainder
                S_DCX, S_DCY: begin
                    r_req.start <= 1'b1;
                    r_req.mode  <= ogf_pkg::ITER_DIV;
                    r_req.steps <= ogf_pkg::DIV_CLAMP_STEPS;
                    r_rem_init  <= RemW'(div_num[NumW-1:ClampQ]);
                    r_bits      <= {div_num[ClampQ-1:0], {(ProdW-ClampQ){1'b0}}};
                    r_den       <= r_mag;
                    r_state     <= (r_state == S_DCX) ? S_WCX : S_WCY;
                end
                S_WCX: begin
                    if (iter_rsp.done) begin
                        r_fx_mag <= clamp_q;
                        r_state  <= S_MCY;
                    end
                end
                S_MCY: begin
                    r_prod  <= mul_p;
                    r_state <= S_DCY;
                end
                S_WCY: begin
                    if (iter_rsp.done) begin
                        r_fy_mag <= clamp_q;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    // magnitudes are at most 7680 here
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_fx    <= r_fx_neg ? -{1'b0, r_fx_mag[FW-2:0]}
                                                : {1'b0, r_fx_mag[FW-2:0]};
                        r_out_fy    <= r_fy_neg ? -{1'b0, r_fy_mag[FW-2:0]}
                                                : {1'b0, r_fy_mag[FW-2:0]};
                        r_out_clamp <= r_clamp;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.force_x     = r_out_fx;
    assign o_out.force_y     = r_out_fy;
    assign o_out.was_clamped = r_out_clamp;
endmodule
